// File: hw/rtl/job_priority_orderer_assert.svh
// assertion macros for the job priority orderer checker
// no dependencies; included by the checker file only
`ifndef JOB_PRIORITY_ORDERER_ASSERT_SVH
`define JOB_PRIORITY_ORDERER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define JPO_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("job priority orderer check failed");

// next-cycle implication, disabled while reset is low
`define JPO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("job priority orderer check failed");

`endif

// File: hw/rtl/jpo_pkg.sv
// shared types and constants for the job priority orderer
// no dependencies; used by jpo_ctrl, jpo_dp and the top level
package jpo_pkg;

    localparam int DEPTH = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int ID_W = 8;
    localparam int PRIO_W = 8;
    localparam int RUN_W = 16;
    localparam int REC_W = ID_W + PRIO_W + RUN_W;

    // packed so that id sits in the lowest bits
    typedef struct packed {
        logic [RUN_W-1:0]  runtime;
        logic [PRIO_W-1:0] priority_v;
        logic [ID_W-1:0]   id;
    } rec_t;

    typedef struct packed {
        logic load;       // store the incoming record or mark overflow
        logic run_init;   // clear scan, rest and emit counters
        logic rd_i;       // read the store at the pass index
        logic rd_j;       // read the store at the compare index
        logic scan_keep;  // move a nonzero record down into the rest area
        logic emit_next;  // a result was taken: step pass and emit counters
        logic sort_init;  // restart the pass index for the sort
        logic cur_load;   // hold the pass record, start compare index after it
        logic cmp;        // compare and maybe exchange with the record read
        logic finish;     // run over: empty the store
        logic out_cur;    // result comes from the held record, else read data
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic rest_empty;
        logic rd_zero;
        logic pass_done;
        logic last_pass;
    } sts_t;

endpackage

// File: hw/rtl/job_priority_orderer.sv
// job priority orderer top level: stream ports around controller and datapath
// depends on jpo_pkg, jpo_ctrl, jpo_dp
//
//   channel   dir   payload                                   end marker
//   s_axis    in    id, priority, runtime                     tlast = last record
//   m_axis    out   id, priority, runtime; tuser = dropped    tlast = last result
//
// records load one per cycle while the block waits for input
// after the last record, the stored records are scanned and those with nonzero priority
// are sorted, with output stalls holding the run; the single store read port sets its pace
// no input is taken from the last record until the final result is taken
// reset empties the store count and clears the overflow mark
module job_priority_orderer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // id[7:0], priority[15:8], runtime[31:16]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // id[7:0], priority[15:8], runtime[31:16]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // dropped[0]
);

    jpo_pkg::cmd_t cmd;
    jpo_pkg::sts_t sts;
    jpo_pkg::rec_t in_rec;
    jpo_pkg::rec_t out_rec;

    assign in_rec       = jpo_pkg::rec_t'(s_axis_tdata);
    assign m_axis_tdata = 32'(out_rec);

    jpo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    jpo_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_rec      (in_rec),
        .sts         (sts),
        .out_rec     (out_rec),
        .out_last    (m_axis_tlast),
        .out_dropped (m_axis_tuser)
    );

endmodule

// File: hw/rtl/jpo_dp.sv
// datapath of the job priority orderer: record store, counters, held record
// depends on jpo_pkg
module jpo_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  jpo_pkg::cmd_t      cmd,
    input  jpo_pkg::rec_t      in_rec,
    output jpo_pkg::sts_t      sts,
    output jpo_pkg::rec_t      out_rec,
    output logic               out_last,
    output logic               out_dropped
);

    logic [jpo_pkg::CNT_W-1:0] count_reg;
    logic [jpo_pkg::CNT_W-1:0] i_reg;
    logic [jpo_pkg::CNT_W-1:0] j_reg;
    logic [jpo_pkg::CNT_W-1:0] nrest_reg;
    logic [jpo_pkg::CNT_W-1:0] e_reg;
    logic                      ovf_reg;
    jpo_pkg::rec_t             cur_reg;
    jpo_pkg::rec_t             rdata_reg;
    jpo_pkg::rec_t             store_reg [jpo_pkg::DEPTH];

    logic                      full;
    logic                      swap;
    logic                      wr_en;
    logic [jpo_pkg::IDX_W-1:0] wr_addr;
    jpo_pkg::rec_t             wr_data;
    logic [jpo_pkg::IDX_W-1:0] rd_addr;

    assign full = (count_reg == jpo_pkg::CNT_W'(jpo_pkg::DEPTH));
    assign swap = (cur_reg.priority_v > rdata_reg.priority_v);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[jpo_pkg::IDX_W-1:0];
        wr_data = in_rec;
        if (cmd.load)
        begin
            wr_en = !full;
        end
        else if (cmd.scan_keep)
        begin
            wr_en   = 1'b1;
            wr_addr = nrest_reg[jpo_pkg::IDX_W-1:0];
            wr_data = rdata_reg;
        end
        else if (cmd.cmp)
        begin
            wr_en   = swap;
            wr_addr = j_reg[jpo_pkg::IDX_W-1:0];
            wr_data = cur_reg;
        end
    end

    assign rd_addr = cmd.rd_j ? j_reg[jpo_pkg::IDX_W-1:0] : i_reg[jpo_pkg::IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (cmd.rd_i || cmd.rd_j)
        begin
            rdata_reg <= store_reg[rd_addr];
        end
        if (cmd.cur_load)
        begin
            cur_reg <= rdata_reg;
        end
        else if (cmd.cmp && swap)
        begin
            cur_reg <= rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            nrest_reg <= '0;
            e_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + jpo_pkg::CNT_W'(1);
                end
            end
            if (cmd.run_init)
            begin
                i_reg     <= '0;
                nrest_reg <= '0;
                e_reg     <= '0;
            end
            if (cmd.scan_keep)
            begin
                nrest_reg <= nrest_reg + jpo_pkg::CNT_W'(1);
                i_reg     <= i_reg + jpo_pkg::CNT_W'(1);
            end
            if (cmd.emit_next)
            begin
                i_reg <= i_reg + jpo_pkg::CNT_W'(1);
                e_reg <= e_reg + jpo_pkg::CNT_W'(1);
            end
            if (cmd.sort_init)
            begin
                i_reg <= '0;
            end
            if (cmd.cur_load)
            begin
                j_reg <= i_reg + jpo_pkg::CNT_W'(1);
            end
            if (cmd.cmp)
            begin
                j_reg <= j_reg + jpo_pkg::CNT_W'(1);
            end
            if (cmd.finish)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.scan_done  = (i_reg == count_reg);
        sts.rest_empty = (nrest_reg == '0);
        sts.rd_zero    = (rdata_reg.priority_v == '0);
        sts.pass_done  = (j_reg == nrest_reg);
        sts.last_pass  = ((i_reg + jpo_pkg::CNT_W'(1)) == nrest_reg);
    end

    // every stored record is given out once, so the run has count results
    assign out_rec     = cmd.out_cur ? cur_reg : rdata_reg;
    assign out_last    = (e_reg == (count_reg - jpo_pkg::CNT_W'(1)));
    assign out_dropped = ovf_reg;

endmodule

// File: hw/rtl/jpo_ctrl.sv
// controller of the job priority orderer: load, scan, sort and emit sequence
// depends on jpo_pkg
module jpo_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_last,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  jpo_pkg::sts_t  sts,
    output jpo_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_LOAD     = 3'd0;
    localparam logic [2:0] ST_SCAN_RD  = 3'd1;
    localparam logic [2:0] ST_SCAN_CHK = 3'd2;
    localparam logic [2:0] ST_SORT_LD  = 3'd3;
    localparam logic [2:0] ST_SORT_CUR = 3'd4;
    localparam logic [2:0] ST_SORT_RD  = 3'd5;
    localparam logic [2:0] ST_SORT_CMP = 3'd6;
    localparam logic [2:0] ST_EMIT     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.run_init = 1'b1;
                        state_next   = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                if (sts.scan_done)
                begin
                    if (sts.rest_empty)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.sort_init = 1'b1;
                        state_next    = ST_SORT_LD;
                    end
                end
                else
                begin
                    cmd.rd_i   = 1'b1;
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                // priority-0 records go straight out in load order
                if (sts.rd_zero)
                begin
                    out_valid = 1'b1;
                    if (out_ready)
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_SCAN_RD;
                    end
                end
                else
                begin
                    cmd.scan_keep = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_SORT_LD:
            begin
                cmd.rd_i   = 1'b1;
                state_next = ST_SORT_CUR;
            end
            ST_SORT_CUR:
            begin
                cmd.cur_load = 1'b1;
                state_next   = ST_SORT_RD;
            end
            ST_SORT_RD:
            begin
                if (sts.pass_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.rd_j   = 1'b1;
                    state_next = ST_SORT_CMP;
                end
            end
            ST_SORT_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = ST_SORT_RD;
            end
            ST_EMIT:
            begin
                // the held record is final for this position once its pass ends
                cmd.out_cur = 1'b1;
                out_valid   = 1'b1;
                if (out_ready)
                begin
                    cmd.emit_next = 1'b1;
                    if (sts.last_pass)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_SORT_LD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// File: hw/rtl/jpo_checker.sv
// port-level checks for the job priority orderer, bound to the top level
// depends on job_priority_orderer_assert.svh
`include "job_priority_orderer_assert.svh"

module jpo_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    logic in_acc;
    logic out_acc;
    logic out_stall;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_acc   = m_axis_tvalid && m_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // no new request while a dispatch run is giving out results
    `JPO_ASSERT_IMPL(a_no_load_during_run, clk, rst_n, m_axis_tvalid, !s_axis_tready)

    // the last record closes the load side until the run ends
    `JPO_ASSERT_NEXT(a_last_in_stalls, clk, rst_n, in_acc && s_axis_tlast, !s_axis_tready)

    // nothing follows the final result of a run
    `JPO_ASSERT_NEXT(a_run_ends, clk, rst_n, out_acc && m_axis_tlast, !m_axis_tvalid)

    // a stalled result holds
    `JPO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable({m_axis_tuser, m_axis_tlast, m_axis_tdata}))

endmodule

bind job_priority_orderer jpo_checker u_jpo_checker (.*);
